[src/sgr_pkg.sv]
// shared types, command codes and the 5x7 font table of the glyph rasterizer
package sgr_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } sgr_cmd_e;

  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 8;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic addr_zero;
    logic sweep;
    logic col_step;
    logic row_init;
    logic row_step;
    logic rmw_write;
    logic read_capture;
  } sgr_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic draw_ok;
    logic col_last;
    logic col_visible;
    logic page_write;
    logic row_last;
    logic rows_done;
  } sgr_stat_t;

  // one entry per printable character, column 0 in the top byte
  localparam logic [39:0] GLYPH_ROM [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0030300000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h304979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
  };

  // font column of a character, bit r = row r; zero outside the printable range
  function automatic logic [7:0] glyph_column(logic [7:0] code, logic [2:0] col);
    logic [39:0] bits;
    logic [7:0]  offs;
    logic [7:0]  res;
    offs = code - CHAR_FIRST;
    if (code >= CHAR_FIRST && code <= CHAR_LAST) begin
      bits = GLYPH_ROM[offs[6:0]];
    end else begin
      bits = '0;
    end
    case (col)
      3'd0:    res = bits[39:32];
      3'd1:    res = bits[31:24];
      3'd2:    res = bits[23:16];
      3'd3:    res = bits[15:8];
      3'd4:    res = bits[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

[src/scaled_glyph_rasterizer.sv]
// scaled glyph rasterizer top level: page-organized framebuffer with 5x7 text drawing
// read: address, framebuffer read and result registered in turn; strobe with the result
// clear: sweeps all WIDTH*ceil(HEIGHT/8) framebuffer bytes, one byte per cycle
// draw: a check state, then the 5*scale screen columns of the cell; each on-screen column
//   with set bits walks 8*scale rows, a read-modify-write per byte written, then done
// reset: busy stays high for a clearing pass of WIDTH*ceil(HEIGHT/8) bytes (1024 by default)
// results cannot be stalled: result_valid_o pulses for one cycle with read_data_o
module scaled_glyph_rasterizer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int SCALE_CAP     = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command transaction: taken when start is high and busy is low
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic signed [7:0] pos_x_i,
  input  logic signed [6:0] pos_y_i,
  input  logic [7:0]        char_code_i,
  input  logic [2:0]        scale_i,
  input  logic [9:0]        byte_index_i,
  // result transaction: one strobe per command
  output logic              result_valid_o,
  output logic [7:0]        read_data_o
);

  sgr_pkg::sgr_ctrl_t ctrl;
  sgr_pkg::sgr_stat_t stat;

  // sequencer: clear sweep, column/row walk of the glyph cell, byte read-back
  sgr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .ctrl_o         (ctrl),
    .stat_i         (stat)
  );

  // framebuffer plus coordinate counters; each on-screen column of the cell that has
  // set bits is walked top to bottom, set pixels collect into a page mask that is ORed in
  // with one read-modify-write per touched byte
  sgr_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .SCALE_CAP     (SCALE_CAP)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .char_code_i  (char_code_i),
    .scale_i      (scale_i),
    .byte_index_i (byte_index_i),
    .read_data_o  (read_data_o)
  );

endmodule

[src/sgr_datapath.sv]
// framebuffer memory, glyph walk counters and read-back register
module sgr_datapath #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int SCALE_CAP     = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgr_pkg::sgr_ctrl_t ctrl_i,
  output sgr_pkg::sgr_stat_t stat_o,
  input  logic signed [7:0] pos_x_i,
  input  logic signed [6:0] pos_y_i,
  input  logic [7:0]        char_code_i,
  input  logic [2:0]        scale_i,
  input  logic [9:0]        byte_index_i,
  output logic [7:0]        read_data_o
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(STORE);
  localparam int IW    = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int SZW   = $clog2(SCALE_CAP + 1);
  localparam int SCW   = (SZW > 3) ? SZW : 3;
  localparam int XW    = $clog2(SCREEN_WIDTH + sgr_pkg::GLYPH_COLS * SCALE_CAP + 128) + 1;
  localparam int YW    = $clog2(SCREEN_HEIGHT + sgr_pkg::GLYPH_ROWS * SCALE_CAP + 64) + 1;

  logic [7:0]           mem [STORE];
  logic [7:0]           rdata_q;
  logic [AW-1:0]        addr_q;
  logic                 in_range_q;
  logic [7:0]           result_q;
  logic [7:0]           code_q;
  logic [SZW-1:0]       size_q;
  logic signed [6:0]    y0_q;
  logic signed [XW-1:0] x_q;
  logic [2:0]           col_q;
  logic [SZW-1:0]       dx_q;
  logic signed [YW-1:0] y_q;
  logic [2:0]           row_q;
  logic [SZW-1:0]       dy_q;
  logic [7:0]           col_bits_q;
  logic [7:0]           mask_q;
  logic [7:0]           wmask_q;
  logic                 rows_done_q;

  logic [IW-1:0]  idx_ext;
  logic           in_range_d;
  logic [SCW-1:0] scale_ext;
  logic [SZW-1:0] size_sat;
  logic [SZW-1:0] size_m1;
  logic [7:0]     col_bits;
  logic           x_vis;
  logic           y_vis;
  logic           bit_on;
  logic [7:0]     mask_now;
  logic           col_last;
  logic           row_last;
  logic           page_end;
  logic [AW-1:0]  page_addr;

  assign idx_ext    = IW'(byte_index_i);
  assign in_range_d = idx_ext < IW'(STORE);
  assign scale_ext  = SCW'(scale_i);
  assign size_sat   = (scale_ext > SCW'(SCALE_CAP)) ? SZW'(SCALE_CAP) : SZW'(scale_ext);
  assign size_m1    = size_q - SZW'(1);

  assign col_bits = sgr_pkg::glyph_column(code_q, col_q);
  assign x_vis    = !x_q[XW-1] && (x_q < $signed(XW'(SCREEN_WIDTH)));
  assign y_vis    = !y_q[YW-1] && (y_q < $signed(YW'(SCREEN_HEIGHT)));
  assign bit_on   = col_bits_q[row_q] && y_vis;
  assign mask_now = mask_q | (bit_on ? (8'h01 << y_q[2:0]) : 8'h00);

  assign col_last = (col_q == 3'(sgr_pkg::GLYPH_COLS - 1)) && (dx_q == size_m1);
  assign row_last = (row_q == 3'(sgr_pkg::GLYPH_ROWS - 1)) && (dy_q == size_m1);
  assign page_end = (&y_q[2:0]) || row_last;

  // byte = x + page * width; only used when the page holds a set pixel (y >= 0)
  assign page_addr = AW'(x_q[XW-2:0]) + AW'(y_q[YW-2:3]) * AW'(SCREEN_WIDTH);

  always_comb begin
    stat_o.sweep_last  = addr_q == AW'(STORE - 1);
    stat_o.draw_ok     = (code_q >= sgr_pkg::CHAR_FIRST) && (code_q <= sgr_pkg::CHAR_LAST)
                         && (size_q != '0);
    stat_o.col_last    = col_last;
    stat_o.col_visible = x_vis && (col_bits != 8'h00);
    stat_o.page_write  = page_end && (mask_now != 8'h00);
    stat_o.row_last    = row_last;
    stat_o.rows_done   = rows_done_q;
  end

  // address register, also the sweep counter of the clearing pass after reset and on a clear command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (ctrl_i.addr_zero) begin
      addr_q <= '0;
    end else if (ctrl_i.load) begin
      addr_q <= AW'(idx_ext);
    end else if (ctrl_i.sweep) begin
      addr_q <= addr_q + AW'(1);
    end else if (ctrl_i.row_step && page_end) begin
      addr_q <= page_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      code_q     <= char_code_i;
      size_q     <= size_sat;
      y0_q       <= pos_y_i;
      x_q        <= XW'(pos_x_i);
      col_q      <= '0;
      dx_q       <= '0;
      in_range_q <= in_range_d;
      result_q   <= 8'h00;
    end
    if (ctrl_i.col_step) begin
      x_q <= x_q + XW'(1);
      if (dx_q == size_m1) begin
        dx_q  <= '0;
        col_q <= col_q + 3'd1;
      end else begin
        dx_q <= dx_q + SZW'(1);
      end
    end
    if (ctrl_i.row_init) begin
      y_q        <= YW'(y0_q);
      row_q      <= '0;
      dy_q       <= '0;
      mask_q     <= 8'h00;
      col_bits_q <= col_bits;
    end
    if (ctrl_i.row_step) begin
      y_q         <= y_q + YW'(1);
      rows_done_q <= row_last;
      if (dy_q == size_m1) begin
        dy_q  <= '0;
        row_q <= row_q + 3'd1;
      end else begin
        dy_q <= dy_q + SZW'(1);
      end
      if (page_end) begin
        wmask_q <= mask_now;
        mask_q  <= 8'h00;
      end else begin
        mask_q <= mask_now;
      end
    end
    if (ctrl_i.read_capture) begin
      result_q <= in_range_q ? rdata_q : 8'h00;
    end
  end

  // single-port framebuffer, registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[addr_q];
    if (ctrl_i.sweep) begin
      mem[addr_q] <= 8'h00;
    end else if (ctrl_i.rmw_write) begin
      mem[addr_q] <= rdata_q | wmask_q;
    end
  end

  assign read_data_o = result_q;

endmodule

[src/sgr_ctrl.sv]
// sequencing state machine of the glyph rasterizer
module sgr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         cmd_i,
  output logic               busy,
  output logic               result_valid_o,
  output sgr_pkg::sgr_ctrl_t ctrl_o,
  input  sgr_pkg::sgr_stat_t stat_i
);

  typedef enum logic [3:0] {
    ST_SWEEP_RST,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAW_CHECK,
    ST_COL,
    ST_ROW,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   valid_q;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_SWEEP_RST: begin
        ctrl_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          case (cmd_i)
            sgr_pkg::CMD_CLEAR: begin
              ctrl_o.addr_zero = 1'b1;
              state_d          = ST_SWEEP;
            end
            sgr_pkg::CMD_DRAW: state_d = ST_DRAW_CHECK;
            sgr_pkg::CMD_READ: state_d = ST_RD_ADDR;
            default:           state_d = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        ctrl_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = ST_DONE;
      end
      ST_DRAW_CHECK: begin
        state_d = stat_i.draw_ok ? ST_COL : ST_DONE;
      end
      ST_COL: begin
        if (stat_i.col_visible) begin
          ctrl_o.row_init = 1'b1;
          state_d         = ST_ROW;
        end else if (stat_i.col_last) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.col_step = 1'b1;
        end
      end
      ST_ROW: begin
        ctrl_o.row_step = 1'b1;
        if (stat_i.page_write) begin
          state_d = ST_RMW_RD;
        end else if (stat_i.row_last) begin
          if (stat_i.col_last) begin
            state_d = ST_DONE;
          end else begin
            ctrl_o.col_step = 1'b1;
            state_d         = ST_COL;
          end
        end
      end
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: begin
        ctrl_o.rmw_write = 1'b1;
        if (!stat_i.rows_done) begin
          state_d = ST_ROW;
        end else if (stat_i.col_last) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.col_step = 1'b1;
          state_d         = ST_COL;
        end
      end
      ST_RD_ADDR: state_d = ST_RD_DATA;
      ST_RD_DATA: begin
        ctrl_o.read_capture = 1'b1;
        state_d             = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP_RST;
      busy_q  <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= state_d != ST_IDLE;
      valid_q <= state_d == ST_DONE;
    end
  end

  assign busy           = busy_q;
  assign result_valid_o = valid_q;

endmodule

[src/sgr_checker.sv]
// port-level checks of the glyph rasterizer, bound to the top level
module sgr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] cmd_i,
  input logic       result_valid_o,
  input logic [7:0] read_data_o
);

  logic [1:0] last_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cmd_q <= sgr_pkg::CMD_NONE;
    end else if (start && !busy) begin
      last_cmd_q <= cmd_i;
    end
  end

  // an accepted command keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted command");

  // the strobe only comes while the command is still in flight
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // one result per command, then ready again
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe longer than one cycle or block stays busy");

  // only a read returns framebuffer data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (last_cmd_q != sgr_pkg::CMD_READ) |-> read_data_o == 8'h00)
    else $error("nonzero data on a non-read result");

endmodule

bind scaled_glyph_rasterizer sgr_checker u_sgr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .read_data_o    (read_data_o)
);
